// ===== sv/ps2_mouse_cursor_tracker_core_defines.svh =====
// Assertion macros shared by the PS/2 cursor tracker modules.
`ifndef PS2_MOUSE_CURSOR_TRACKER_CORE_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside of reset.
`define PS2MCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside of reset.
`define PS2MCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ps2mct_pkg.sv =====
// Shared types and constants of the PS/2 cursor tracker.
package ps2mct_pkg;

    // Screen geometry
    localparam int TEXT_COLS   = 80;
    localparam int TEXT_ROWS   = 25;
    localparam int VIRT_WIDTH  = 640;
    localparam int VIRT_HEIGHT = 400;

    // Field widths
    localparam int X_W   = 10;
    localparam int Y_W   = 9;
    localparam int COL_W = 7;
    localparam int ROW_W = 5;

    // Header byte bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_ONE    = 3;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;
    localparam int HDR_XOVF   = 6;
    localparam int HDR_YOVF   = 7;

    // Column scaling: col = (x * TEXT_COLS) * COL_RECIP >> COL_SHIFT
    localparam int CMUL_W    = $clog2(TEXT_COLS + 1);
    localparam int PX_W      = X_W + CMUL_W;
    localparam int COL_SHIFT = PX_W + $clog2(VIRT_WIDTH);
    localparam int CRCP_W    = PX_W + 1;
    localparam longint unsigned COL_RECIP =
        ((64'd1 << COL_SHIFT) + VIRT_WIDTH - 1) / VIRT_WIDTH;

    // Row scaling: row = (y * TEXT_ROWS) * ROW_RECIP >> ROW_SHIFT
    localparam int RMUL_W    = $clog2(TEXT_ROWS + 1);
    localparam int PY_W      = Y_W + RMUL_W;
    localparam int ROW_SHIFT = PY_W + $clog2(VIRT_HEIGHT);
    localparam int RRCP_W    = PY_W + 1;
    localparam longint unsigned ROW_RECIP =
        ((64'd1 << ROW_SHIFT) + VIRT_HEIGHT - 1) / VIRT_HEIGHT;

    // Packet queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Output stream width
    localparam int OUT_BITS = COL_W + ROW_W + X_W + Y_W + 3;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Byte position within a packet
    typedef enum logic [1:0] {
        SLOT_HDR = 2'd0,
        SLOT_DX  = 2'd1,
        SLOT_DY  = 2'd2
    } t_slot;

    // Validated packet handed from front to back
    typedef struct packed {
        logic       left;
        logic       middle;
        logic       right;
        logic       x_sign;
        logic       y_sign;
        logic [7:0] dx;
        logic [7:0] dy;
    } t_pkt;

endpackage

// ===== sv/ps2mct_front.sv =====
// Byte gathering and packet validation of the PS/2 cursor tracker.
`include "ps2_mouse_cursor_tracker_core_defines.svh"

module ps2mct_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
    input  logic              i_q_full,
    output logic              o_push,
    output ps2mct_pkg::t_pkt  o_pkt
);

    ps2mct_pkg::t_slot r_slot, n_slot;
    logic [7:0]        r_hdr, n_hdr;
    logic [7:0]        r_dx, n_dx;
    logic              w_beat;
    logic              w_hdr_ok;

    assign w_beat = s_axis_tvalid && s_axis_tready;

    // Advance the byte slot on each beat
    always_comb begin
        n_slot = r_slot;
        if (w_beat) begin
            case (r_slot)
                ps2mct_pkg::SLOT_HDR: n_slot = ps2mct_pkg::SLOT_DX;
                ps2mct_pkg::SLOT_DX:  n_slot = ps2mct_pkg::SLOT_DY;
                ps2mct_pkg::SLOT_DY:  n_slot = ps2mct_pkg::SLOT_HDR;
                default:              n_slot = ps2mct_pkg::SLOT_DX;
            endcase
        end
    end

    // Capture header and X byte, stall only the last byte on a full queue
    always_comb begin
        n_hdr    = r_hdr;
        n_dx     = r_dx;
        o_push   = 1'b0;
        w_hdr_ok = r_hdr[ps2mct_pkg::HDR_ONE] && !r_hdr[ps2mct_pkg::HDR_XOVF]
                   && !r_hdr[ps2mct_pkg::HDR_YOVF];
        s_axis_tready = (r_slot != ps2mct_pkg::SLOT_DY) || !i_q_full;
        case (r_slot)
            ps2mct_pkg::SLOT_DX: begin
                if (w_beat) n_dx = s_axis_tdata;
            end
            ps2mct_pkg::SLOT_DY: begin
                o_push = w_beat && w_hdr_ok;
            end
            default: begin
                if (w_beat) n_hdr = s_axis_tdata;
            end
        endcase
    end

    // Assemble the packet for the queue
    always_comb begin
        o_pkt.left   = r_hdr[ps2mct_pkg::HDR_LEFT];
        o_pkt.middle = r_hdr[ps2mct_pkg::HDR_MIDDLE];
        o_pkt.right  = r_hdr[ps2mct_pkg::HDR_RIGHT];
        o_pkt.x_sign = r_hdr[ps2mct_pkg::HDR_XSIGN];
        o_pkt.y_sign = r_hdr[ps2mct_pkg::HDR_YSIGN];
        o_pkt.dx     = r_dx;
        o_pkt.dy     = s_axis_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= ps2mct_pkg::SLOT_HDR;
            r_hdr  <= 8'd0;
            r_dx   <= 8'd0;
        end else begin
            r_slot <= n_slot;
            r_hdr  <= n_hdr;
            r_dx   <= n_dx;
        end
    end

    `PS2MCT_ASSERT_NOW(a_push_last_byte, o_push,
        (r_slot == ps2mct_pkg::SLOT_DY) && !i_q_full, "push outside last byte or into full queue")
    `PS2MCT_ASSERT_NOW(a_stall_last_byte, !s_axis_tready,
        (r_slot == ps2mct_pkg::SLOT_DY) && i_q_full, "input stalled without a full queue")
    `PS2MCT_ASSERT_NEXT(a_wrap_after_last, w_beat && (r_slot == ps2mct_pkg::SLOT_DY),
        r_slot == ps2mct_pkg::SLOT_HDR, "slot did not return to header")

endmodule

// ===== sv/ps2mct_queue.sv =====
// Short packet queue between the front and back of the cursor tracker.
`include "ps2_mouse_cursor_tracker_core_defines.svh"

module ps2mct_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ps2mct_pkg::t_pkt  i_pkt,
    input  logic              i_pop,
    output ps2mct_pkg::t_pkt  o_pkt,
    output logic              o_full,
    output logic              o_empty
);

    ps2mct_pkg::t_pkt                  r_mem [ps2mct_pkg::QDEPTH];
    logic [ps2mct_pkg::QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [ps2mct_pkg::QCNT_W-1:0]     r_count, n_count;

    assign o_full  = (r_count == ps2mct_pkg::QCNT_W'(ps2mct_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_pkt   = r_mem[r_rd_ptr];

    // Track fill level
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

    `PS2MCT_ASSERT_NOW(a_no_pop_empty, i_pop, !o_empty, "pop from empty queue")
    `PS2MCT_ASSERT_NOW(a_no_push_full, i_push, !o_full || i_pop, "push into full queue")
    `PS2MCT_ASSERT_NOW(a_count_bound, 1'b1,
        r_count <= ps2mct_pkg::QCNT_W'(ps2mct_pkg::QDEPTH), "queue count beyond depth")

endmodule

// ===== sv/ps2mct_back.sv =====
// Position update, text-cell scaling and output register of the cursor tracker.
`include "ps2_mouse_cursor_tracker_core_defines.svh"

module ps2mct_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  ps2mct_pkg::t_pkt               i_pkt,
    output logic                           o_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [6:0] cursor_col, [11:7] cursor_row, [21:12] pointer_x, [30:22] pointer_y,
    // [31] left_button, [32] middle_button, [33] right_button, rest zero
    output logic [ps2mct_pkg::OUT_W-1:0]   m_axis_tdata
);

    localparam int X_W    = ps2mct_pkg::X_W;
    localparam int Y_W    = ps2mct_pkg::Y_W;
    localparam int SUM_W  = ((X_W > Y_W) ? X_W : Y_W) + 2;
    localparam int CPRD_W = ps2mct_pkg::PX_W + ps2mct_pkg::CRCP_W;
    localparam int RPRD_W = ps2mct_pkg::PY_W + ps2mct_pkg::RRCP_W;
    localparam logic [ps2mct_pkg::CMUL_W-1:0] COLS_K = ps2mct_pkg::CMUL_W'(ps2mct_pkg::TEXT_COLS);
    localparam logic [ps2mct_pkg::RMUL_W-1:0] ROWS_K = ps2mct_pkg::RMUL_W'(ps2mct_pkg::TEXT_ROWS);
    localparam logic [ps2mct_pkg::CRCP_W-1:0] CRCP_K = ps2mct_pkg::CRCP_W'(ps2mct_pkg::COL_RECIP);
    localparam logic [ps2mct_pkg::RRCP_W-1:0] RRCP_K = ps2mct_pkg::RRCP_W'(ps2mct_pkg::ROW_RECIP);
    localparam logic [X_W-1:0] X_MAX = X_W'(ps2mct_pkg::VIRT_WIDTH - 1);
    localparam logic [Y_W-1:0] Y_MAX = Y_W'(ps2mct_pkg::VIRT_HEIGHT - 1);

    logic                 w_adv;
    logic signed [9:0]    w_mx_sum, w_my_sum;
    logic signed [7:0]    w_hx, w_hy;
    logic signed [SUM_W-1:0] w_x_sum, w_y_sum;
    logic [X_W-1:0]       n_x;
    logic [Y_W-1:0]       n_y;

    // Stage A: position state
    logic                 r_a_vld;
    logic [2:0]           r_a_btn;
    logic [X_W-1:0]       r_x;
    logic [Y_W-1:0]       r_y;

    // Stage B: scaled products
    logic                 r_b_vld;
    logic [2:0]           r_b_btn;
    logic [X_W-1:0]       r_b_x;
    logic [Y_W-1:0]       r_b_y;
    logic [ps2mct_pkg::PX_W-1:0] r_b_px;
    logic [ps2mct_pkg::PY_W-1:0] r_b_py;

    // Stage C: output register
    logic                 r_c_vld;
    logic [2:0]           r_c_btn;
    logic [X_W-1:0]       r_c_x;
    logic [Y_W-1:0]       r_c_y;
    logic [ps2mct_pkg::COL_W-1:0] r_c_col;
    logic [ps2mct_pkg::ROW_W-1:0] r_c_row;

    logic [CPRD_W-1:0]    w_cprod;
    logic [RPRD_W-1:0]    w_rprod;

    // Advance the whole back pipeline unless the output beat is stalled
    assign w_adv = !r_c_vld || m_axis_tready;
    assign o_pop = w_adv && !i_empty;

    // Halve the 9-bit movements toward zero
    always_comb begin
        w_mx_sum = {{1{i_pkt.x_sign}}, i_pkt.x_sign, i_pkt.dx}
                   + {9'd0, i_pkt.x_sign};
        w_my_sum = {{1{i_pkt.y_sign}}, i_pkt.y_sign, i_pkt.dy}
                   + {9'd0, i_pkt.y_sign};
        w_hx = w_mx_sum[8:1];
        w_hy = w_my_sum[8:1];
    end

    // Move and clamp the virtual position
    always_comb begin
        w_x_sum = $signed({2'b00, r_x}) + SUM_W'(w_hx);
        w_y_sum = $signed({{(SUM_W-Y_W){1'b0}}, r_y}) - SUM_W'(w_hy);
        if (w_x_sum < 0)                                n_x = '0;
        else if (w_x_sum > $signed({2'b00, X_MAX}))     n_x = X_MAX;
        else                                            n_x = w_x_sum[X_W-1:0];
        if (w_y_sum < 0)                                            n_y = '0;
        else if (w_y_sum > $signed({{(SUM_W-Y_W){1'b0}}, Y_MAX}))   n_y = Y_MAX;
        else                                                        n_y = w_y_sum[Y_W-1:0];
    end

    // Divide by the virtual size through a reciprocal multiply
    assign w_cprod = CPRD_W'(r_b_px) * CPRD_W'(CRCP_K);
    assign w_rprod = RPRD_W'(r_b_py) * RPRD_W'(RRCP_K);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_x     <= X_W'(ps2mct_pkg::VIRT_WIDTH / 2);
            r_y     <= Y_W'(ps2mct_pkg::VIRT_HEIGHT / 2);
        end else if (w_adv) begin
            r_a_vld <= !i_empty;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            if (!i_empty) begin
                r_x <= n_x;
                r_y <= n_y;
            end
        end
    end

    // Payload of the three stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_btn <= {i_pkt.right, i_pkt.middle, i_pkt.left};
            r_b_btn <= r_a_btn;
            r_b_x   <= r_x;
            r_b_y   <= r_y;
            r_b_px  <= ps2mct_pkg::PX_W'(r_x) * ps2mct_pkg::PX_W'(COLS_K);
            r_b_py  <= ps2mct_pkg::PY_W'(r_y) * ps2mct_pkg::PY_W'(ROWS_K);
            r_c_btn <= r_b_btn;
            r_c_x   <= r_b_x;
            r_c_y   <= r_b_y;
            r_c_col <= w_cprod[ps2mct_pkg::COL_SHIFT +: ps2mct_pkg::COL_W];
            r_c_row <= w_rprod[ps2mct_pkg::ROW_SHIFT +: ps2mct_pkg::ROW_W];
        end
    end

    assign m_axis_tvalid = r_c_vld;
    assign m_axis_tdata  = ps2mct_pkg::OUT_W'({r_c_btn, r_c_y, r_c_x, r_c_row, r_c_col});

    `PS2MCT_ASSERT_NOW(a_x_in_range, 1'b1, r_x <= X_MAX, "virtual x beyond width")
    `PS2MCT_ASSERT_NOW(a_y_in_range, 1'b1, r_y <= Y_MAX, "virtual y beyond height")
    `PS2MCT_ASSERT_NEXT(a_stall_holds_col, m_axis_tvalid && !m_axis_tready,
        $stable(r_c_col) && $stable(r_c_x), "stalled result changed")

endmodule

// ===== sv/ps2_mouse_cursor_tracker_core.sv =====
// Top level of the PS/2 mouse cursor tracker.
//
// Input stream: one PS/2 mouse byte per beat on s_axis_tdata. Every three
// beats form a packet (header, X movement, Y movement). A packet with the
// always-one header bit clear or an overflow bit set yields no result.
// Output stream: one beat per valid packet with the text cell, the clamped
// virtual position and the three buttons.
// Throughput: one byte per cycle while the packet queue has room. Bytes are
// accepted while a result waits at the output; a two-entry packet queue
// separates byte gathering from the position update, so only the last byte
// of a packet waits when that queue is full.
// Path: the third byte pushes the packet into the queue; the queue read with
// the position add and clamp fills stage A, the constant multiply stage B
// and the reciprocal multiply the output register, stage C.
// Reset: synchronous, active low; the packet slot returns to the header and
// the pointer returns to the center of the virtual area.
// Output stall: the output register and back pipeline hold; the queue then
// fills and finally s_axis_tready drops on the third byte of a packet.

module ps2_mouse_cursor_tracker_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [6:0] cursor_col, [11:7] cursor_row, [21:12] pointer_x, [30:22] pointer_y,
    // [31] left_button, [32] middle_button, [33] right_button, rest zero
    output logic [ps2mct_pkg::OUT_W-1:0]   m_axis_tdata
);

    logic              w_push, w_pop, w_full, w_empty;
    ps2mct_pkg::t_pkt  w_front_pkt, w_back_pkt;

    // Gather bytes and drop bad packets
    ps2mct_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_pkt         (w_front_pkt)
    );

    // Decouple front and back
    ps2mct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_front_pkt),
        .i_pop   (w_pop),
        .o_pkt   (w_back_pkt),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Update position and emit the cursor beat
    ps2mct_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_pkt         (w_back_pkt),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking stream testbench for the PS/2 mouse cursor tracker core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 20;
    localparam int TOTAL_BYTES = 1250;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 16;
    localparam int MAX_SHOWN   = 10;

    // One output beat, lowest field last so it lands in the low bits
    typedef struct packed {
        logic                         right;
        logic                         middle;
        logic                         left;
        logic [ps2mct_pkg::Y_W-1:0]   y;
        logic [ps2mct_pkg::X_W-1:0]   x;
        logic [ps2mct_pkg::ROW_W-1:0] row;
        logic [ps2mct_pkg::COL_W-1:0] col;
    } t_cursor;

    localparam int CUR_BITS = $bits(t_cursor);

    // One directed byte, with a hand-written result where one is pinned
    typedef struct packed {
        logic [7:0] data;
        logic       pinned;
        logic       fires;
        t_cursor    want;
    } t_script_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // [7:0] data_byte
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // [6:0] cursor_col, [11:7] cursor_row, [21:12] pointer_x, [30:22] pointer_y,
    // [31] left_button, [32] middle_button, [33] right_button, rest zero
    logic [ps2mct_pkg::OUT_W-1:0] m_axis_tdata;

    // Tracker state mirrored by the predictor
    ps2mct_pkg::t_slot          pkt_slot;
    logic [7:0]                 pkt_hdr;
    logic [7:0]                 pkt_dx;
    logic [ps2mct_pkg::X_W-1:0] pos_x;
    logic [ps2mct_pkg::Y_W-1:0] pos_y;

    t_cursor        pending_cursor[$];
    t_script_row    script[$];
    int             bytes_fed   = 0;
    int             mismatches  = 0;
    int             idle_cycles = 0;
    int             src_run     = 0;
    int             sink_run    = 0;

    ps2_mouse_cursor_tracker_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Advance the packet tracker by one byte; return 1 when a cursor beat is due
    function automatic logic track_byte(input logic [7:0] b, output t_cursor res);
        int   step_x;
        int   step_y;
        int   nx;
        int   ny;
        logic fired;
        res   = '0;
        fired = 1'b0;
        case (pkt_slot)
            ps2mct_pkg::SLOT_DX: begin
                pkt_dx   = b;
                pkt_slot = ps2mct_pkg::SLOT_DY;
            end
            ps2mct_pkg::SLOT_DY: begin
                pkt_slot = ps2mct_pkg::SLOT_HDR;
                // drop on a clear always-one bit or either overflow
                if (pkt_hdr[ps2mct_pkg::HDR_ONE] && !pkt_hdr[ps2mct_pkg::HDR_XOVF] &&
                    !pkt_hdr[ps2mct_pkg::HDR_YOVF]) begin
                    // nine-bit signed movement, halved toward zero
                    step_x = (pkt_hdr[ps2mct_pkg::HDR_XSIGN] ? int'(pkt_dx) - 256
                                                             : int'(pkt_dx)) / 2;
                    step_y = (pkt_hdr[ps2mct_pkg::HDR_YSIGN] ? int'(b) - 256
                                                             : int'(b)) / 2;
                    nx = int'(pos_x) + step_x;
                    ny = int'(pos_y) - step_y;
                    if (nx < 0) nx = 0;
                    else if (nx > ps2mct_pkg::VIRT_WIDTH - 1) nx = ps2mct_pkg::VIRT_WIDTH - 1;
                    if (ny < 0) ny = 0;
                    else if (ny > ps2mct_pkg::VIRT_HEIGHT - 1) ny = ps2mct_pkg::VIRT_HEIGHT - 1;
                    pos_x      = ps2mct_pkg::X_W'(nx);
                    pos_y      = ps2mct_pkg::Y_W'(ny);
                    res.col    = ps2mct_pkg::COL_W'(int'(pos_x) * ps2mct_pkg::TEXT_COLS /
                                                    ps2mct_pkg::VIRT_WIDTH);
                    res.row    = ps2mct_pkg::ROW_W'(int'(pos_y) * ps2mct_pkg::TEXT_ROWS /
                                                    ps2mct_pkg::VIRT_HEIGHT);
                    res.x      = pos_x;
                    res.y      = pos_y;
                    res.left   = pkt_hdr[ps2mct_pkg::HDR_LEFT];
                    res.middle = pkt_hdr[ps2mct_pkg::HDR_MIDDLE];
                    res.right  = pkt_hdr[ps2mct_pkg::HDR_RIGHT];
                    fired      = 1'b1;
                end
            end
            default: begin
                pkt_hdr  = b;
                pkt_slot = ps2mct_pkg::SLOT_DX;
            end
        endcase
        return fired;
    endfunction

    // Draw a wait in cycles, with occasional runs of back-to-back beats
    function automatic int pick_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic add_step(input logic [7:0] data, input logic pinned, input logic fires,
                            input t_cursor want);
        t_script_row r;
        r.data   = data;
        r.pinned = pinned;
        r.fires  = fires;
        r.want   = want;
        script.push_back(r);
    endtask

    // Send one byte beat, then record what it should produce
    task automatic feed_byte(input logic [7:0] b, input logic pinned, input logic fires,
                             input t_cursor want);
        int      gap;
        t_cursor guess;
        gap = pick_wait(src_run);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        if (track_byte(b, guess) && !pinned) pending_cursor.push_back(guess);
        if (pinned && fires) pending_cursor.push_back(want);
        bytes_fed++;
    endtask

    // Hold the input side until every pending cursor beat has arrived
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_cursor.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input t_cursor want, input t_cursor got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display({"%0t: %s: expected col=%0d row=%0d x=%0d y=%0d lmr=%b%b%b, ",
                      "got col=%0d row=%0d x=%0d y=%0d lmr=%b%b%b pad=%h"},
                     $time, what, want.col, want.row, want.x, want.y,
                     want.left, want.middle, want.right,
                     got.col, got.row, got.x, got.y, got.left, got.middle, got.right,
                     m_axis_tdata[ps2mct_pkg::OUT_W-1:CUR_BITS]);
    endtask

    // Accept cursor beats with random stalls and check them in order
    initial begin : result_sink
        int      stall;
        t_cursor want;
        t_cursor got;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = pick_wait(sink_run);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = t_cursor'(m_axis_tdata[CUR_BITS-1:0]);
            if (pending_cursor.size() == 0) begin
                report_mismatch("unexpected beat", '0, got);
            end else begin
                want = pending_cursor.pop_front();
                if (got.col !== want.col || got.row !== want.row ||
                    got.x !== want.x || got.y !== want.y ||
                    got.left !== want.left || got.middle !== want.middle ||
                    got.right !== want.right ||
                    m_axis_tdata[ps2mct_pkg::OUT_W-1:CUR_BITS] !== '0)
                    report_mismatch("field mismatch", want, got);
            end
        end
    end

    // End the run when neither side moves a beat for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("ps2_mouse_cursor_tracker_core regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_cursor    centered;
        logic [7:0] hdr;
        logic [7:0] dx;
        logic [7:0] dy;
        logic       drift_left;
        logic       drift_down;
        logic       drained_mid;
        int         pick;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        pkt_slot      = ps2mct_pkg::SLOT_HDR;
        pkt_hdr       = 8'h00;
        pkt_dx        = 8'h00;
        pos_x         = ps2mct_pkg::X_W'(ps2mct_pkg::VIRT_WIDTH / 2);
        pos_y         = ps2mct_pkg::Y_W'(ps2mct_pkg::VIRT_HEIGHT / 2);
        drift_left    = 1'b0;
        drift_down    = 1'b0;
        drained_mid   = 1'b0;

        // Still packet right after reset: pointer stays at the center
        centered        = '0;
        centered.col    = 7'd40;
        centered.row    = 5'd12;
        centered.x      = 10'd320;
        centered.y      = 9'd200;
        add_step(8'h08, 1'b0, 1'b0, '0);
        add_step(8'h00, 1'b0, 1'b0, '0);
        add_step(8'h00, 1'b1, 1'b1, centered);
        // All buttons, X byte 0x7F, Y byte 0x80 without sign
        add_step(8'h0F, 1'b0, 1'b0, '0);
        add_step(8'h7F, 1'b0, 1'b0, '0);
        add_step(8'h80, 1'b0, 1'b0, '0);
        // Minus one on both axes halves to no movement
        add_step(8'h3F, 1'b0, 1'b0, '0);
        add_step(8'hFF, 1'b0, 1'b0, '0);
        add_step(8'hFF, 1'b0, 1'b0, '0);
        // Most negative X
        add_step(8'h18, 1'b0, 1'b0, '0);
        add_step(8'h00, 1'b0, 1'b0, '0);
        add_step(8'h00, 1'b0, 1'b0, '0);
        // Most negative Y moves the pointer down
        add_step(8'h28, 1'b0, 1'b0, '0);
        add_step(8'h00, 1'b0, 1'b0, '0);
        add_step(8'h00, 1'b0, 1'b0, '0);
        // Dropped: always-one bit clear
        add_step(8'h00, 1'b0, 1'b0, '0);
        add_step(8'h55, 1'b0, 1'b0, '0);
        add_step(8'h55, 1'b1, 1'b0, '0);
        // Dropped: X overflow
        add_step(8'h48, 1'b0, 1'b0, '0);
        add_step(8'h01, 1'b0, 1'b0, '0);
        add_step(8'h01, 1'b1, 1'b0, '0);
        // Dropped: Y overflow
        add_step(8'h88, 1'b0, 1'b0, '0);
        add_step(8'h01, 1'b0, 1'b0, '0);
        add_step(8'h01, 1'b1, 1'b0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i])
            feed_byte(script[i].data, script[i].pinned, script[i].fires, script[i].want);

        // Random packets: mostly well formed, drifting so both clamps get hit
        while (bytes_fed < TOTAL_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick == 0 || (!drained_mid && bytes_fed >= TOTAL_BYTES / 2)) begin
                drain_results();
                drained_mid = 1'b1;
            end
            if ($urandom_range(0, 29) == 0) drift_left = ~drift_left;
            if ($urandom_range(0, 29) == 0) drift_down = ~drift_down;
            if (pick < 85) begin
                hdr = 8'($urandom);
                dx  = 8'($urandom);
                dy  = 8'($urandom);
                hdr[ps2mct_pkg::HDR_ONE]  = 1'b1;
                hdr[ps2mct_pkg::HDR_XOVF] = 1'b0;
                hdr[ps2mct_pkg::HDR_YOVF] = 1'b0;
                if ($urandom_range(0, 1) == 1) begin
                    hdr[ps2mct_pkg::HDR_XSIGN] = drift_left;
                    dx = drift_left ? 8'($urandom_range(0, 40)) : 8'($urandom_range(215, 255));
                end
                if ($urandom_range(0, 1) == 1) begin
                    hdr[ps2mct_pkg::HDR_YSIGN] = drift_down;
                    dy = drift_down ? 8'($urandom_range(0, 40)) : 8'($urandom_range(215, 255));
                end
                feed_byte(hdr, 1'b0, 1'b0, '0);
                feed_byte(dx, 1'b0, 1'b0, '0);
                feed_byte(dy, 1'b0, 1'b0, '0);
            end else if (pick < 95) begin
                // noise packet, often dropped
                repeat (3) feed_byte(8'($urandom), 1'b0, 1'b0, '0);
            end else begin
                // stray byte shifts the framing
                feed_byte(8'($urandom), 1'b0, 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("ps2_mouse_cursor_tracker_core regression: pass");
        else
            $display("ps2_mouse_cursor_tracker_core regression: fail");
        $finish;
    end

endmodule
